FILE: hdl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants for the pressure/temperature compensation
// pipeline: payload structs, calibration set, register indexes and the
// stage records handed between the pipeline modules.
// ----------------------------------------------------------------------------
package ptc_pkg;

	// Register file
	localparam int unsigned CAL_W     = 16;
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRESSURE_SENSITIVITY = 3'd0,
		REG_PRESSURE_OFFSET      = 3'd1,
		REG_SENS_TEMP_COEFF      = 3'd2,
		REG_OFFSET_TEMP_COEFF    = 3'd3,
		REG_REFERENCE_TEMP       = 3'd4,
		REG_TEMP_COEFF           = 3'd5
	} ptc_reg_e;

	// Fixed datapath constants
	localparam logic signed [19:0] TEMP_REF  = 20'sd2000;   // 20.00 C
	localparam logic signed [18:0] TA_VLOW   = -19'sd3500;  // -15.00 C relative to 20.00 C
	localparam logic signed [19:0] TB_OFFSET = 20'sd3500;   // TEMP + 1500 == TA + 3500
	localparam logic signed [19:0] TEMP_MIN  = -20'sd4000;
	localparam logic signed [19:0] TEMP_MAX  = 20'sd8500;
	localparam logic signed [34:0] PRES_MAX  = 35'sd300000;

	// Payloads
	typedef struct packed {
		logic [23:0] raw_pressure;
		logic [23:0] raw_temperature;
	} ptc_in_t;

	typedef struct packed {
		logic signed [14:0] temperature;
		logic [18:0]        pressure;
		logic               clipped;
	} ptc_out_t;

	typedef struct packed {
		logic [CAL_W-1:0] pressure_sensitivity;
		logic [CAL_W-1:0] pressure_offset;
		logic [CAL_W-1:0] sens_temp_coeff;
		logic [CAL_W-1:0] offset_temp_coeff;
		logic [CAL_W-1:0] reference_temp;
		logic [CAL_W-1:0] temp_coeff;
	} ptc_cal_t;

	// First-order results leaving stage 3
	typedef struct packed {
		logic               valid;
		logic [23:0]        d1;
		logic signed [18:0] ta;     // TEMP - 2000
		logic signed [19:0] tb;     // TEMP + 1500
		logic               low;    // below 20.00 C
		logic               vlow;   // below -15.00 C
		logic signed [35:0] off;
		logic signed [34:0] sens;
		logic [16:0]        ti;
	} ptc_first_t;

	// Second-order terms leaving stage 5
	typedef struct packed {
		logic               valid;
		logic [23:0]        d1;
		logic signed [19:0] t2;
		logic signed [35:0] off;
		logic signed [34:0] sens;
		logic [40:0]        offi;
		logic [40:0]        sensi;
	} ptc_second_t;

endpackage

FILE: hdl/ptc_first_order.sv
// ----------------------------------------------------------------------------
// ptc_first_order
// Stages 1 to 3: temperature difference, three calibration products, its square,
// first-order temperature, offset, sensitivity and temperature correction.
// ----------------------------------------------------------------------------
module ptc_first_order import ptc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  ptc_in_t    in_item,
	input  ptc_cal_t   cal,
	output ptc_first_t first
);

	// Stage 1: dT = D2 - C5 * 256
	logic signed [25:0] dt_full;
	logic               valid_s1;
	logic [23:0]        d1_s1;
	logic signed [24:0] dt_s1;

	assign dt_full = $signed({2'b00, in_item.raw_temperature})
		- $signed({2'b00, cal.reference_temp, 8'h00});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		d1_s1 <= in_item.raw_pressure;
		dt_s1 <= dt_full[24:0];
	end

	// Stage 2: calibration products and dT squared
	logic signed [41:0] mul_t;
	logic signed [41:0] mul_off;
	logic signed [41:0] mul_sens;
	logic signed [49:0] mul_sq;
	logic               valid_s2;
	logic [23:0]        d1_s2;
	logic signed [41:0] prod_t_s2;
	logic signed [41:0] prod_off_s2;
	logic signed [41:0] prod_sens_s2;
	logic [47:0]        dtsq_s2;

	assign mul_t    = dt_s1 * $signed({1'b0, cal.temp_coeff});
	assign mul_off  = dt_s1 * $signed({1'b0, cal.offset_temp_coeff});
	assign mul_sens = dt_s1 * $signed({1'b0, cal.sens_temp_coeff});
	assign mul_sq   = dt_s1 * dt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		d1_s2        <= d1_s1;
		prod_t_s2    <= mul_t;
		prod_off_s2  <= mul_off;
		prod_sens_s2 <= mul_sens;
		dtsq_s2      <= mul_sq[47:0];
	end

	// Stage 3: shift down the products and form first-order values
	logic signed [18:0] ta_c;
	logic signed [19:0] tb_c;
	logic signed [35:0] off_c;
	logic signed [34:0] sens_c;
	logic [49:0]        dtsq3;
	logic [16:0]        ti_lo;
	logic [16:0]        ti_hi;
	ptc_first_t         first_s3;

	assign ta_c   = prod_t_s2[41:23];
	assign tb_c   = $signed({ta_c[18], ta_c}) + TB_OFFSET;
	assign off_c  = $signed({4'b0000, cal.pressure_offset, 16'h0000})
		+ $signed({prod_off_s2[41], prod_off_s2[41:7]});
	assign sens_c = $signed({4'b0000, cal.pressure_sensitivity, 15'h0000})
		+ $signed({prod_sens_s2[41], prod_sens_s2[41:8]});
	assign dtsq3  = {2'b00, dtsq_s2} + {1'b0, dtsq_s2, 1'b0};
	assign ti_lo  = dtsq3[49:33];
	assign ti_hi  = {5'b00000, dtsq_s2[47:36]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_s3 <= '0;
		end else begin
			first_s3.valid <= valid_s2;
			first_s3.d1    <= d1_s2;
			first_s3.ta    <= ta_c;
			first_s3.tb    <= tb_c;
			first_s3.low   <= ta_c[18];
			first_s3.vlow  <= (ta_c < TA_VLOW);
			first_s3.off   <= off_c;
			first_s3.sens  <= sens_c;
			first_s3.ti    <= ta_c[18] ? ti_lo : ti_hi;
		end
	end

	assign first = first_s3;

endmodule

FILE: hdl/ptc_second_order.sv
// ----------------------------------------------------------------------------
// ptc_second_order
// Stages 4 and 5: squares of the temperature offsets, corrected temperature
// and the second-order offset and sensitivity terms for each branch.
// ----------------------------------------------------------------------------
module ptc_second_order import ptc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ptc_first_t  first,
	output ptc_second_t second
);

	// Stage 4: squares and corrected temperature
	logic signed [37:0] mul_ta;
	logic signed [39:0] mul_tb;
	logic signed [19:0] t2_c;
	logic               valid_s4;
	logic [23:0]        d1_s4;
	logic [36:0]        ta2_s4;
	logic [36:0]        tb2_s4;
	logic signed [19:0] t2_s4;
	logic               low_s4;
	logic               vlow_s4;
	logic signed [35:0] off_s4;
	logic signed [34:0] sens_s4;

	assign mul_ta = first.ta * first.ta;
	assign mul_tb = first.tb * first.tb;
	assign t2_c   = $signed({first.ta[18], first.ta}) + TEMP_REF
		- $signed({3'b000, first.ti});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= first.valid;
		end
	end

	always_ff @(posedge clk) begin
		d1_s4   <= first.d1;
		ta2_s4  <= mul_ta[36:0];
		tb2_s4  <= mul_tb[36:0];
		t2_s4   <= t2_c;
		low_s4  <= first.low;
		vlow_s4 <= first.vlow;
		off_s4  <= first.off;
		sens_s4 <= first.sens;
	end

	// Stage 5: OFFi and SENSi by shift and add
	logic [38:0] ta2_x3;
	logic [38:0] ta2_x5;
	logic [39:0] tb2_x7;
	logic [38:0] tb2_x4;
	logic [40:0] offi_c;
	logic [40:0] sensi_c;
	ptc_second_t second_s5;

	assign ta2_x3 = {2'b00, ta2_s4} + {1'b0, ta2_s4, 1'b0};
	assign ta2_x5 = {2'b00, ta2_s4} + {ta2_s4, 2'b00};
	assign tb2_x7 = {tb2_s4, 3'b000} - {3'b000, tb2_s4};
	assign tb2_x4 = {tb2_s4, 2'b00};

	always_comb begin
		if (low_s4) begin
			offi_c  = {3'b000, ta2_x3[38:1]} + (vlow_s4 ? {1'b0, tb2_x7} : 41'd0);
			sensi_c = {5'b00000, ta2_x5[38:3]} + (vlow_s4 ? {2'b00, tb2_x4} : 41'd0);
		end else begin
			offi_c  = {8'h00, ta2_s4[36:4]};
			sensi_c = 41'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_s5 <= '0;
		end else begin
			second_s5.valid <= valid_s4;
			second_s5.d1    <= d1_s4;
			second_s5.t2    <= t2_s4;
			second_s5.off   <= off_s4;
			second_s5.sens  <= sens_s4;
			second_s5.offi  <= offi_c;
			second_s5.sensi <= sensi_c;
		end
	end

	assign second = second_s5;

endmodule

FILE: hdl/ptc_pressure.sv
// ----------------------------------------------------------------------------
// ptc_pressure
// Stages 6 to 9: net offset and sensitivity, the wide D1 product split into
// two partial products, final pressure and saturation of both results.
// ----------------------------------------------------------------------------
module ptc_pressure import ptc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ptc_second_t second,
	output logic        done,
	output ptc_out_t    result
);

	// Stage 6: OFF - OFFi and SENS - SENSi
	logic               valid_s6;
	logic [23:0]        d1_s6;
	logic signed [19:0] t2_s6;
	logic signed [42:0] off_net_s6;
	logic signed [42:0] sens_net_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else begin
			valid_s6 <= second.valid;
		end
	end

	always_ff @(posedge clk) begin
		d1_s6       <= second.d1;
		t2_s6       <= second.t2;
		off_net_s6  <= $signed({{7{second.off[35]}}, second.off})
			- $signed({2'b00, second.offi});
		sens_net_s6 <= $signed({{8{second.sens[34]}}, second.sens})
			- $signed({2'b00, second.sensi});
	end

	// Stage 7: partial products of D1 with the high and low halves
	logic signed [46:0] mul_hi;
	logic signed [46:0] mul_lo;
	logic               valid_s7;
	logic signed [19:0] t2_s7;
	logic signed [42:0] off_net_s7;
	logic signed [46:0] part_hi_s7;
	logic signed [46:0] part_lo_s7;

	assign mul_hi = $signed({1'b0, d1_s6}) * $signed(sens_net_s6[42:21]);
	assign mul_lo = $signed({1'b0, d1_s6}) * $signed({1'b0, sens_net_s6[20:0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		t2_s7      <= t2_s6;
		off_net_s7 <= off_net_s6;
		part_hi_s7 <= mul_hi;
		part_lo_s7 <= mul_lo;
	end

	// Stage 8: combine the partial products
	logic               valid_s8;
	logic signed [19:0] t2_s8;
	logic signed [42:0] off_net_s8;
	logic signed [67:0] prod_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else begin
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		t2_s8      <= t2_s7;
		off_net_s8 <= off_net_s7;
		prod_s8    <= $signed({part_hi_s7, 21'd0})
			+ $signed({{21{part_lo_s7[46]}}, part_lo_s7});
	end

	// Stage 9: subtract offset, scale and saturate
	logic signed [47:0] q_c;
	logic signed [34:0] p2_c;
	logic               pres_low;
	logic               pres_high;
	logic               temp_low;
	logic               temp_high;
	ptc_out_t           out_c;
	logic               done_s9;
	ptc_out_t           result_s9;

	assign q_c       = $signed({prod_s8[67], prod_s8[67:21]})
		- $signed({{5{off_net_s8[42]}}, off_net_s8});
	assign p2_c      = q_c[47:13];
	assign pres_low  = p2_c[34];
	assign pres_high = (p2_c > PRES_MAX);
	assign temp_low  = (t2_s8 < TEMP_MIN);
	assign temp_high = (t2_s8 > TEMP_MAX);

	always_comb begin
		out_c.clipped = pres_low | pres_high | temp_low | temp_high;
		if (temp_low) begin
			out_c.temperature = TEMP_MIN[14:0];
		end else if (temp_high) begin
			out_c.temperature = TEMP_MAX[14:0];
		end else begin
			out_c.temperature = t2_s8[14:0];
		end
		if (pres_low) begin
			out_c.pressure = 19'd0;
		end else if (pres_high) begin
			out_c.pressure = PRES_MAX[18:0];
		end else begin
			out_c.pressure = p2_c[18:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s9 <= 1'b0;
		end else begin
			done_s9 <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		result_s9 <= out_c;
	end

	assign done   = done_s9;
	assign result = result_s9;

endmodule

FILE: hdl/pressure_temp_compensation_top.sv
// ----------------------------------------------------------------------------
// pressure_temp_compensation_top
// Second-order compensation of a raw 24-bit pressure/temperature pair into
// temperature (0.01 C) and pressure (0.1 mbar), saturated with a clip flag.
//
//   Channel   Ports                               Transfer condition
//   -------   ---------------------------------   ------------------------
//   input     start, busy, sample                 start high, busy low
//   result    done, result                        done high (one cycle)
//   config    cfg_write, cfg_index, cfg_wdata     cfg_write high
//
// One pair enters per clock. The datapath has nine register stages, the first
// loaded at the start transfer edge and the last driving done and result.
// busy never rises.
// Reset clears the calibration words and the stage valid bits.
// The result side has no back-pressure, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module pressure_temp_compensation_top import ptc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  ptc_in_t              sample,
	output logic                 done,
	output ptc_out_t             result,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CAL_W-1:0]     cfg_wdata
);

	ptc_cal_t    cal_q;
	ptc_first_t  first;
	ptc_second_t second;

	// Calibration register file; writes beyond the last index are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_write) begin
			case (ptc_reg_e'(cfg_index))
				REG_PRESSURE_SENSITIVITY: cal_q.pressure_sensitivity <= cfg_wdata;
				REG_PRESSURE_OFFSET:      cal_q.pressure_offset      <= cfg_wdata;
				REG_SENS_TEMP_COEFF:      cal_q.sens_temp_coeff      <= cfg_wdata;
				REG_OFFSET_TEMP_COEFF:    cal_q.offset_temp_coeff    <= cfg_wdata;
				REG_REFERENCE_TEMP:       cal_q.reference_temp       <= cfg_wdata;
				REG_TEMP_COEFF:           cal_q.temp_coeff           <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Fully pipelined: always ready for the next pair
	assign busy = 1'b0;

	ptc_first_order u_first (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(start & ~busy),
		.in_item (sample),
		.cal     (cal_q),
		.first   (first)
	);

	ptc_second_order u_second (
		.clk   (clk),
		.arst_n(arst_n),
		.first (first),
		.second(second)
	);

	ptc_pressure u_pressure (
		.clk   (clk),
		.arst_n(arst_n),
		.second(second),
		.done  (done),
		.result(result)
	);

endmodule

FILE: verif/ptc_compensation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_compensation_checker
// Watches the calibration port and both data channels of the compensation
// block. It keeps a mirror of the calibration words and computes the expected
// temperature, pressure and clip flag for every accepted sample. Each reading
// is compared field by field with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module ptc_compensation_checker import ptc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  ptc_in_t              sample,
	input  logic                 done,
	input  ptc_out_t             result,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CAL_W-1:0]     cfg_wdata,
	output int                   mismatches,
	output int                   readings_pending
);

	localparam longint TEMP_REF_CC   = 2000;
	localparam longint TEMP_COLD_CC  = -1500;
	localparam longint TEMP_FLOOR_CC = -4000;
	localparam longint TEMP_CEIL_CC  = 8500;
	localparam longint PRES_CEIL     = 300000;

	ptc_cal_t cal_mirror;
	ptc_out_t expected_readings[$];

	// Second-order compensation of one raw pair under a calibration set
	function automatic ptc_out_t compensate(input ptc_in_t s, input ptc_cal_t c);
		longint d1, d2, c1, c2, c3, c4, c5, c6;
		longint dtemp, temp1, offset, sens, dev, dev_cold;
		longint t_corr, off_corr, sens_corr, t2, p2;
		logic clip;
		ptc_out_t r;
		d1 = s.raw_pressure;
		d2 = s.raw_temperature;
		c1 = c.pressure_sensitivity;
		c2 = c.pressure_offset;
		c3 = c.sens_temp_coeff;
		c4 = c.offset_temp_coeff;
		c5 = c.reference_temp;
		c6 = c.temp_coeff;

		// first order
		dtemp  = d2 - c5 * 256;
		temp1  = TEMP_REF_CC + ((dtemp * c6) >>> 23);
		offset = c2 * 65536 + ((c4 * dtemp) >>> 7);
		sens   = c1 * 32768 + ((c3 * dtemp) >>> 8);

		// second order, split on the 20 C and -15 C thresholds
		dev = temp1 - TEMP_REF_CC;
		if (temp1 < TEMP_REF_CC) begin
			t_corr    = (3 * dtemp * dtemp) >>> 33;
			off_corr  = (3 * dev * dev) >>> 1;
			sens_corr = (5 * dev * dev) >>> 3;
			if (temp1 < TEMP_COLD_CC) begin
				dev_cold  = temp1 - TEMP_COLD_CC;
				off_corr  = off_corr + 7 * dev_cold * dev_cold;
				sens_corr = sens_corr + 4 * dev_cold * dev_cold;
			end
		end else begin
			t_corr    = (2 * dtemp * dtemp) >>> 37;
			off_corr  = (dev * dev) >>> 4;
			sens_corr = 0;
		end

		t2 = temp1 - t_corr;
		p2 = (((d1 * (sens - sens_corr)) >>> 21) - (offset - off_corr)) >>> 13;

		// saturate to the sensor range
		clip = 1'b0;
		if (t2 < TEMP_FLOOR_CC) begin
			t2 = TEMP_FLOOR_CC;
			clip = 1'b1;
		end
		if (t2 > TEMP_CEIL_CC) begin
			t2 = TEMP_CEIL_CC;
			clip = 1'b1;
		end
		if (p2 < 0) begin
			p2 = 0;
			clip = 1'b1;
		end
		if (p2 > PRES_CEIL) begin
			p2 = PRES_CEIL;
			clip = 1'b1;
		end

		r.temperature = t2[14:0];
		r.pressure    = p2[18:0];
		r.clipped     = clip;
		return r;
	endfunction

	// Track calibration, queue expectations, compare readings
	always @(posedge clk or negedge arst_n) begin : watch
		ptc_out_t want;
		int n_bad;
		if (!arst_n) begin
			cal_mirror       <= '0;
			mismatches       <= 0;
			readings_pending <= 0;
			expected_readings.delete();
		end else begin
			n_bad = 0;

			// retire the oldest expectation on each reading
			if (done) begin
				if (expected_readings.size() == 0) begin
					$display("%0t: unexpected reading: expected none, got temperature=%0d pressure=%0d clipped=%0b",
						$time, result.temperature, result.pressure, result.clipped);
					n_bad++;
				end else begin
					want = expected_readings.pop_front();
					if (result.temperature !== want.temperature) begin
						$display("%0t: temperature mismatch: expected %0d, got %0d",
							$time, want.temperature, result.temperature);
						n_bad++;
					end
					if (result.pressure !== want.pressure) begin
						$display("%0t: pressure mismatch: expected %0d, got %0d",
							$time, want.pressure, result.pressure);
						n_bad++;
					end
					if (result.clipped !== want.clipped) begin
						$display("%0t: clip flag mismatch: expected %0b, got %0b",
							$time, want.clipped, result.clipped);
						n_bad++;
					end
				end
			end

			// predict with the calibration in force before this edge
			if (start && !busy)
				expected_readings.push_back(compensate(sample, cal_mirror));

			// mirror register writes; spare indexes are dropped
			if (cfg_write) begin
				case (ptc_reg_e'(cfg_index))
					REG_PRESSURE_SENSITIVITY: cal_mirror.pressure_sensitivity <= cfg_wdata;
					REG_PRESSURE_OFFSET:      cal_mirror.pressure_offset      <= cfg_wdata;
					REG_SENS_TEMP_COEFF:      cal_mirror.sens_temp_coeff      <= cfg_wdata;
					REG_OFFSET_TEMP_COEFF:    cal_mirror.offset_temp_coeff    <= cfg_wdata;
					REG_REFERENCE_TEMP:       cal_mirror.reference_temp       <= cfg_wdata;
					REG_TEMP_COEFF:           cal_mirror.temp_coeff           <= cfg_wdata;
					default: ;
				endcase
			end

			mismatches       <= mismatches + n_bad;
			readings_pending <= expected_readings.size();
		end
	end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for pressure_temp_compensation_top. Runs directed pairs on the
// branch thresholds and range limits under zero, datasheet and all-ones
// calibration, then random pairs under changing calibration with light,
// heavy and no gaps between start transfers. Checking is done by the
// checker instance; this module drives stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
	import ptc_pkg::*;

	typedef enum int {
		CAL_ZERO,
		CAL_TYPICAL,
		CAL_FULL,
		CAL_RANDOM
	} cal_kind_e;

	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

	// datasheet calibration example
	localparam logic [CAL_W-1:0] TYP_C1 = 16'd34982;
	localparam logic [CAL_W-1:0] TYP_C2 = 16'd36352;
	localparam logic [CAL_W-1:0] TYP_C3 = 16'd20328;
	localparam logic [CAL_W-1:0] TYP_C4 = 16'd22354;
	localparam logic [CAL_W-1:0] TYP_C5 = 16'd26646;
	localparam logic [CAL_W-1:0] TYP_C6 = 16'd26146;

	localparam int RAW_MAX     = 24'hFFFFFF;
	localparam int IDLE_LIGHT  = 19;
	localparam int IDLE_HEAVY  = 72;
	localparam int N_CHUNKS    = 6;
	localparam int CHUNK_ITEMS = 125;
	localparam int TAIL_CYCLES = 24;
	localparam int CYCLE_LIMIT = 100000;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	ptc_in_t              sample    = '0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CAL_W-1:0]     cfg_wdata = '0;
	logic                 busy;
	logic                 done;
	ptc_out_t             result;
	int                   mismatches;
	int                   readings_pending;
	int                   cycle_count = 0;
	int                   ref_raw = 0;

	pressure_temp_compensation_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.sample    (sample),
		.done      (done),
		.result    (result),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	ptc_compensation_checker u_chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.sample           (sample),
		.done             (done),
		.result           (result),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.mismatches       (mismatches),
		.readings_pending (readings_pending)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("pressure_temp_compensation_top regression: fail");
			$finish;
		end
	end

	// Hold one sample until its start transfer, then maybe leave a gap
	task automatic send_sample(input ptc_in_t s, input int idle_pct);
		start  <= 1'b1;
		sample <= s;
		do @(posedge clk); while (busy);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	// Stop sending and wait until every reading has come back
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (readings_pending != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	// Load a full calibration set, then hit the spare indexes
	task automatic load_cal(input cal_kind_e kind);
		ptc_cal_t w;
		case (kind)
			CAL_ZERO:    w = '0;
			CAL_FULL:    w = '1;
			CAL_TYPICAL: w = {TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6};
			default:     w = {$urandom, $urandom, $urandom};
		endcase
		write_reg(REG_PRESSURE_SENSITIVITY, w.pressure_sensitivity);
		write_reg(REG_PRESSURE_OFFSET, w.pressure_offset);
		write_reg(REG_SENS_TEMP_COEFF, w.sens_temp_coeff);
		write_reg(REG_OFFSET_TEMP_COEFF, w.offset_temp_coeff);
		write_reg(REG_REFERENCE_TEMP, w.reference_temp);
		write_reg(REG_TEMP_COEFF, w.temp_coeff);
		write_reg(IDX_SPARE_LO, 16'($urandom_range(16'hFFFF)));
		write_reg(IDX_SPARE_HI, 16'($urandom_range(16'hFFFF)));
		cfg_write <= 1'b0;
		ref_raw = int'(w.reference_temp) << 8;
	endtask

	// Mostly plausible readings near the reference temperature, rest anywhere
	function automatic ptc_in_t random_sample();
		ptc_in_t s;
		int d2;
		s.raw_pressure    = 24'($urandom_range(RAW_MAX));
		s.raw_temperature = 24'($urandom_range(RAW_MAX));
		if ($urandom_range(99) >= 30) begin
			d2 = ref_raw + int'($urandom_range(3000000)) - 1500000;
			if (d2 < 0)
				d2 = 0;
			else if (d2 > RAW_MAX)
				d2 = RAW_MAX;
			s.raw_temperature = d2[23:0];
			s.raw_pressure    = 24'($urandom_range(9000000, 2000000));
		end
		return s;
	endfunction

	initial begin
		cal_kind_e kind;
		int idle_pct;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// uncalibrated block, raw extremes
		send_sample({24'h000000, 24'h000000}, 0);
		send_sample({24'hFFFFFF, 24'hFFFFFF}, 0);
		send_sample({24'hFFFFFF, 24'h000000}, 0);
		send_sample({24'h000000, 24'hFFFFFF}, 0);
		drain();

		// datasheet calibration: branch thresholds and clamps
		load_cal(CAL_TYPICAL);
		send_sample({24'd6465444, 24'd8077636}, 0);
		send_sample({24'd6465444, 24'd6821376}, 0);   // exactly 20.00 C
		send_sample({24'd6465444, 24'd6821375}, 0);   // just below 20.00 C
		send_sample({24'd6465444, 24'd5698446}, 0);   // exactly -15.00 C
		send_sample({24'd6465444, 24'd5698445}, 0);   // just below -15.00 C
		send_sample({24'd6465444, 24'd0}, 0);         // clamp cold
		send_sample({24'd6465444, 24'hFFFFFF}, 0);    // clamp hot
		send_sample({24'd0, 24'd8077636}, 0);         // pressure below zero
		send_sample({24'hFFFFFF, 24'd8077636}, 0);    // pressure over range
		send_sample({24'd4000000, 24'd7500000}, 0);
		send_sample({24'd8000000, 24'd6000000}, 0);
		drain();

		// all-ones calibration
		load_cal(CAL_FULL);
		send_sample({24'h000000, 24'h000000}, 0);
		send_sample({24'hFFFFFF, 24'hFFFFFF}, 0);
		send_sample({24'h800000, 24'hFFFF00}, 0);

		// random chunks; each calibration change follows a full drain
		for (int chunk = 0; chunk < N_CHUNKS; chunk++) begin
			drain();
			kind = (chunk == 2) ? CAL_FULL : (chunk % 2) ? CAL_RANDOM : CAL_TYPICAL;
			idle_pct = (chunk < 2) ? IDLE_LIGHT : (chunk < 4) ? IDLE_HEAVY : 0;
			load_cal(kind);
			repeat (CHUNK_ITEMS) send_sample(random_sample(), idle_pct);
		end
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && readings_pending == 0)
			$display("pressure_temp_compensation_top regression: pass");
		else
			$display("pressure_temp_compensation_top regression: fail");
		$finish;
	end

endmodule
